// ===== hw/rtl/keda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keda_pkg
// Shared types and constants of the kinetic energy density accumulator:
// operand and accumulator select codes, the controller states, and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package keda_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF    = 20;
  localparam int SUM_WIDTH_DEF    = 48;

  // Intermediate values are signed 64-bit, saturated to +-(2^63-1).
  localparam int DW          = 64;
  localparam int MAG_W       = DW - 1;
  localparam int PROD_W      = MAG_W + DW;
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = DW / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

  localparam int NUM_STEPS = 23;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_K_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_K_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_K_Z = 2'd2;

  typedef enum logic [4:0] {
    OP_PR,
    OP_PI,
    OP_GXR,
    OP_GXI,
    OP_GYR,
    OP_GYI,
    OP_GZR,
    OP_GZI,
    OP_KX,
    OP_KY,
    OP_KZ,
    OP_OCC,
    OP_KSQ,
    OP_PSQ,
    OP_IM,
    OP_QUAD,
    OP_KC
  } opnd_t;

  typedef enum logic [2:0] {
    ACC_ZERO,
    ACC_GSQ,
    ACC_KSQ,
    ACC_IM,
    ACC_KC,
    ACC_PSQ,
    ACC_QUAD,
    ACC_TERM
  } acc_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_INIT,
    S_MUL_DIGIT,
    S_ROUND,
    S_ACCUM,
    S_FINAL
  } ctrl_state_t;

  // One multiply-accumulate step: dst = sat(c +- round(a*b / 2^sh)).
  typedef struct packed {
    opnd_t sel_a;
    opnd_t sel_b;
    acc_t  sel_c;
    acc_t  dst;
    logic  negate;
    logic  half;
  } mac_cmd_t;

  typedef struct packed {
    logic     load;
    logic     mul_init;
    logic     mul_digit;
    logic     round;
    logic     accum;
    logic     final_add;
    mac_cmd_t mac;
  } dp_cmd_t;

  typedef struct packed {
    logic last_band;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kinetic_energy_density_accumulate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kinetic_energy_density_accumulate
// Per-point accumulator of 0.5*w*|grad psi + i*k*psi|^2 over bands.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one band per beat: eight signed complex sample
//   components and the occupancy in s_tdata, the closing band of a point on
//   s_tlast. The configuration channel writes the Bloch vector k_x, k_y, k_z
//   at indexes 0 to 2; other indexes are ignored. Write it only while idle.
//   Each band runs 23 multiply-accumulate steps through one shared 63x16
//   multiplier, each product in four digits plus setup, round and add: a
//   band keeps s_tready low from its accept until its final add, so a new
//   band is taken only once the last is through. A beat with s_tlast
//   produces one master beat, carrying the Q27.20 sum in m_tdata and the
//   clip flag in m_tuser, in the cycle after the final add; the sum and
//   flag then clear for the next point.
//   The result sits in an output register, so the next band is taken while
//   it waits. If the receiver stalls, a later closing band waits in its last
//   cycle until the register frees. Reset clears k, the sum and the flag.
// ----------------------------------------------------------------------------
module kinetic_energy_density_accumulate
  import keda_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
  localparam int OCC_W       = FRAC_BITS + 2,
  localparam int IN_DATA_W   = ((8 * SAMPLE_WIDTH + OCC_W + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((SUM_WIDTH + 7) / 8) * 8
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // psi_re, psi_im, gx_re, gx_im, gy_re, gy_im, gz_re, gz_im, occupancy
  input  logic [IN_DATA_W-1:0]    s_tdata,
  input  logic                    s_tlast,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // density_sum
  output logic [OUT_DATA_W-1:0]   m_tdata,
  // saturated
  output logic                    m_tuser,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [SAMPLE_WIDTH-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  keda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  keda_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_sat   (m_tuser)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/keda_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keda_ctrl
// Sequencer that walks the fixed program of multiply-accumulate steps for
// one band and issues datapath commands for each digit of every product.
// ----------------------------------------------------------------------------
module keda_ctrl
  import keda_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST = DIGIT_CNT_W'(NUM_DIGITS - 1);
  localparam logic [STEP_W-1:0]      STEP_LAST  = STEP_W'(NUM_STEPS - 1);

  ctrl_state_t             state, state_next;
  logic [STEP_W-1:0]       step, step_next;
  logic [DIGIT_CNT_W-1:0]  digit, digit_next;

  function automatic mac_cmd_t mac_step(input logic [STEP_W-1:0] idx);
    mac_cmd_t m;
    m = '{sel_a: OP_PR, sel_b: OP_PR, sel_c: ACC_ZERO, dst: ACC_ZERO,
          negate: 1'b0, half: 1'b0};
    case (idx)
      5'd0:  begin m.sel_a = OP_GXR; m.sel_b = OP_GXR; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd1:  begin m.sel_a = OP_GXI; m.sel_b = OP_GXI; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd2:  begin m.sel_a = OP_GYR; m.sel_b = OP_GYR; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd3:  begin m.sel_a = OP_GYI; m.sel_b = OP_GYI; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd4:  begin m.sel_a = OP_GZR; m.sel_b = OP_GZR; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd5:  begin m.sel_a = OP_GZI; m.sel_b = OP_GZI; m.sel_c = ACC_GSQ; m.dst = ACC_GSQ; end
      5'd6:  begin m.sel_a = OP_KX;  m.sel_b = OP_KX;  m.sel_c = ACC_KSQ; m.dst = ACC_KSQ; end
      5'd7:  begin m.sel_a = OP_PR;  m.sel_b = OP_GXI; m.sel_c = ACC_ZERO; m.dst = ACC_IM; end
      5'd8:  begin
        m.sel_a = OP_PI; m.sel_b = OP_GXR; m.sel_c = ACC_IM; m.dst = ACC_IM; m.negate = 1'b1;
      end
      5'd9:  begin m.sel_a = OP_KX;  m.sel_b = OP_IM;  m.sel_c = ACC_KC;  m.dst = ACC_KC;  end
      5'd10: begin m.sel_a = OP_KY;  m.sel_b = OP_KY;  m.sel_c = ACC_KSQ; m.dst = ACC_KSQ; end
      5'd11: begin m.sel_a = OP_PR;  m.sel_b = OP_GYI; m.sel_c = ACC_ZERO; m.dst = ACC_IM; end
      5'd12: begin
        m.sel_a = OP_PI; m.sel_b = OP_GYR; m.sel_c = ACC_IM; m.dst = ACC_IM; m.negate = 1'b1;
      end
      5'd13: begin m.sel_a = OP_KY;  m.sel_b = OP_IM;  m.sel_c = ACC_KC;  m.dst = ACC_KC;  end
      5'd14: begin m.sel_a = OP_KZ;  m.sel_b = OP_KZ;  m.sel_c = ACC_KSQ; m.dst = ACC_KSQ; end
      5'd15: begin m.sel_a = OP_PR;  m.sel_b = OP_GZI; m.sel_c = ACC_ZERO; m.dst = ACC_IM; end
      5'd16: begin
        m.sel_a = OP_PI; m.sel_b = OP_GZR; m.sel_c = ACC_IM; m.dst = ACC_IM; m.negate = 1'b1;
      end
      5'd17: begin m.sel_a = OP_KZ;  m.sel_b = OP_IM;  m.sel_c = ACC_KC;  m.dst = ACC_KC;  end
      5'd18: begin m.sel_a = OP_PR;  m.sel_b = OP_PR;  m.sel_c = ACC_ZERO; m.dst = ACC_PSQ; end
      5'd19: begin m.sel_a = OP_PI;  m.sel_b = OP_PI;  m.sel_c = ACC_PSQ; m.dst = ACC_PSQ; end
      5'd20: begin m.sel_a = OP_KSQ; m.sel_b = OP_PSQ; m.sel_c = ACC_GSQ; m.dst = ACC_QUAD; end
      5'd21: begin
        m.sel_a = OP_QUAD; m.sel_b = OP_OCC; m.sel_c = ACC_ZERO; m.dst = ACC_TERM; m.half = 1'b1;
      end
      5'd22: begin m.sel_a = OP_KC;  m.sel_b = OP_OCC; m.sel_c = ACC_TERM; m.dst = ACC_TERM; end
      default: begin
        m.dst = ACC_ZERO;
      end
    endcase
    return m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      digit <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      digit <= digit_next;
    end
  end

  always_comb begin
    state_next    = state;
    step_next     = step;
    digit_next    = digit;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_init  = 1'b0;
    cmd.mul_digit = 1'b0;
    cmd.round     = 1'b0;
    cmd.accum     = 1'b0;
    cmd.final_add = 1'b0;
    cmd.mac       = mac_step(step);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        step_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL_INIT;
        end
      end
      S_MUL_INIT: begin
        cmd.mul_init = 1'b1;
        digit_next   = '0;
        state_next   = S_MUL_DIGIT;
      end
      S_MUL_DIGIT: begin
        cmd.mul_digit = 1'b1;
        digit_next    = digit + 1'b1;
        if (digit == DIGIT_LAST) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_FINAL;
        end else begin
          step_next  = step + 1'b1;
          state_next = S_MUL_INIT;
        end
      end
      S_FINAL: begin
        // A closing band must wait for the output register to free up.
        if (!status.last_band || status.out_free) begin
          cmd.final_add = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_digit_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_DIGIT && digit == DIGIT_LAST) |=> (state == S_ROUND))
    else $error("multiplier digit sequence did not end in rounding");

  a_program_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCUM && step == STEP_LAST) |=> (state == S_FINAL))
    else $error("step program did not end in the final accumulate");

  a_open_band_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL && !status.last_band) |=> (state == S_IDLE))
    else $error("a band that does not close its point stalled in the final add");

endmodule
`default_nettype wire

// ===== hw/rtl/keda_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keda_datapath
// Operand registers, a digit-serial multiplier with round and saturate, the
// saturating step accumulators, the running sum and the output register.
// ----------------------------------------------------------------------------
module keda_datapath
  import keda_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
  localparam int OCC_W       = FRAC_BITS + 2,
  localparam int IN_DATA_W   = ((8 * SAMPLE_WIDTH + OCC_W + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((SUM_WIDTH + 7) / 8) * 8
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  logic [IN_DATA_W-1:0]          in_data,
  input  logic                          in_last,
  input  logic                          cfg_valid,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]       cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [OUT_DATA_W-1:0]         out_data,
  output logic                          out_sat
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int FW = DW + 2;
  localparam logic [PROD_W-1:0] RND_F  = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] RND_F1 = PROD_W'(1) << FRAC_BITS;
  localparam logic [MAG_W-1:0]  MAG_MAX = '1;
  localparam logic signed [DW:0] SAT_HI = {2'b00, {(DW - 1){1'b1}}};
  localparam logic signed [DW:0] SAT_LO = -SAT_HI;
  localparam logic [FW-1:0] ONE_F = FW'(1);
  localparam logic signed [FW-1:0] SUM_HI = $signed((ONE_F << (SUM_WIDTH - 1)) - ONE_F);
  localparam logic signed [FW-1:0] SUM_LO = (SUM_WIDTH == DW) ? -SUM_HI : -SUM_HI - 1;

  // Latched item fields and Bloch vector registers.
  logic signed [SW-1:0] psi_re, psi_im, gx_re, gx_im, gy_re, gy_im, gz_re, gz_im;
  logic [OCC_W-1:0]     occupancy;
  logic                 last_band;
  logic signed [SW-1:0] k_x, k_y, k_z;

  // Step accumulators.
  logic signed [DW-1:0] gsq, ksq, im, kc, psq, quad, term;

  // Multiplier.
  logic [MAG_W-1:0]     ua;
  logic [DW-1:0]        ub;
  logic [PROD_W-1:0]    prod;
  logic [MAG_W-1:0]     mag;
  logic                 neg;
  logic [MAG_W+DIGIT_W-1:0] digit_prod;

  logic signed [SUM_WIDTH-1:0] running_sum;
  logic                        clip_seen;

  logic signed [DW-1:0]   opa, opb, opc;
  logic signed [DW-1:0]   a_abs, b_abs;
  logic [PROD_W-1:0]      rnd_sum, rnd_shift;
  logic                   rnd_clip;
  logic signed [DW-1:0]   p_val;
  logic signed [DW:0]     acc_raw;
  logic signed [DW-1:0]   acc_sat;
  logic                   acc_clip;
  logic signed [FW-1:0]   fin_raw;
  logic signed [SUM_WIDTH-1:0] fin_sat;
  logic                   fin_clip;
  logic                   emit;

  function automatic logic signed [DW-1:0] sext(input logic signed [SW-1:0] x);
    return {{(DW - SW){x[SW-1]}}, x};
  endfunction

  always_comb begin
    case (cmd.mac.sel_a)
      OP_PR:   opa = sext(psi_re);
      OP_PI:   opa = sext(psi_im);
      OP_GXR:  opa = sext(gx_re);
      OP_GXI:  opa = sext(gx_im);
      OP_GYR:  opa = sext(gy_re);
      OP_GYI:  opa = sext(gy_im);
      OP_GZR:  opa = sext(gz_re);
      OP_GZI:  opa = sext(gz_im);
      OP_KX:   opa = sext(k_x);
      OP_KY:   opa = sext(k_y);
      OP_KZ:   opa = sext(k_z);
      OP_OCC:  opa = DW'(occupancy);
      OP_KSQ:  opa = ksq;
      OP_PSQ:  opa = psq;
      OP_IM:   opa = im;
      OP_QUAD: opa = quad;
      OP_KC:   opa = kc;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cmd.mac.sel_b)
      OP_PR:   opb = sext(psi_re);
      OP_PI:   opb = sext(psi_im);
      OP_GXR:  opb = sext(gx_re);
      OP_GXI:  opb = sext(gx_im);
      OP_GYR:  opb = sext(gy_re);
      OP_GYI:  opb = sext(gy_im);
      OP_GZR:  opb = sext(gz_re);
      OP_GZI:  opb = sext(gz_im);
      OP_KX:   opb = sext(k_x);
      OP_KY:   opb = sext(k_y);
      OP_KZ:   opb = sext(k_z);
      OP_OCC:  opb = DW'(occupancy);
      OP_KSQ:  opb = ksq;
      OP_PSQ:  opb = psq;
      OP_IM:   opb = im;
      OP_QUAD: opb = quad;
      OP_KC:   opb = kc;
      default: opb = '0;
    endcase
  end

  always_comb begin
    case (cmd.mac.sel_c)
      ACC_ZERO: opc = '0;
      ACC_GSQ:  opc = gsq;
      ACC_KSQ:  opc = ksq;
      ACC_IM:   opc = im;
      ACC_KC:   opc = kc;
      ACC_PSQ:  opc = psq;
      ACC_QUAD: opc = quad;
      ACC_TERM: opc = term;
      default:  opc = '0;
    endcase
  end

  // Operands never reach -2^63, so their magnitudes fit in 63 bits.
  assign a_abs = opa[DW-1] ? -opa : opa;
  assign b_abs = opb[DW-1] ? -opb : opb;

  // One 63x16 partial product per digit cycle, sized so no bit is lost.
  assign digit_prod = {{DIGIT_W{1'b0}}, ua} * {{MAG_W{1'b0}}, ub[DW-1 -: DIGIT_W]};

  // Round half away from zero on the magnitude, then clip to 2^63-1.
  assign rnd_sum   = prod + (cmd.mac.half ? RND_F1 : RND_F);
  assign rnd_shift = cmd.mac.half ? (rnd_sum >> (FRAC_BITS + 1)) : (rnd_sum >> FRAC_BITS);
  assign rnd_clip  = |rnd_shift[PROD_W-1:MAG_W];

  assign p_val   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign acc_raw = {opc[DW-1], opc} + {p_val[DW-1], p_val};

  always_comb begin
    acc_clip = 1'b0;
    acc_sat  = acc_raw[DW-1:0];
    if (acc_raw > SAT_HI) begin
      acc_clip = 1'b1;
      acc_sat  = SAT_HI[DW-1:0];
    end else if (acc_raw < SAT_LO) begin
      acc_clip = 1'b1;
      acc_sat  = SAT_LO[DW-1:0];
    end
  end

  assign fin_raw = {{(FW - SUM_WIDTH){running_sum[SUM_WIDTH-1]}}, running_sum}
                 + {{(FW - DW){term[DW-1]}}, term};

  always_comb begin
    fin_clip = 1'b0;
    fin_sat  = fin_raw[SUM_WIDTH-1:0];
    if (fin_raw > SUM_HI) begin
      fin_clip = 1'b1;
      fin_sat  = SUM_HI[SUM_WIDTH-1:0];
    end else if (fin_raw < SUM_LO) begin
      fin_clip = 1'b1;
      fin_sat  = SUM_LO[SUM_WIDTH-1:0];
    end
  end

  assign emit = cmd.final_add && last_band;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_x <= '0;
      k_y <= '0;
      k_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_K_X: k_x <= cfg_data;
        CFG_K_Y: k_y <= cfg_data;
        CFG_K_Z: k_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Item fields, step accumulators and the multiplier.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      psi_re    <= in_data[0 * SW +: SW];
      psi_im    <= in_data[1 * SW +: SW];
      gx_re     <= in_data[2 * SW +: SW];
      gx_im     <= in_data[3 * SW +: SW];
      gy_re     <= in_data[4 * SW +: SW];
      gy_im     <= in_data[5 * SW +: SW];
      gz_re     <= in_data[6 * SW +: SW];
      gz_im     <= in_data[7 * SW +: SW];
      occupancy <= in_data[8 * SW +: OCC_W];
      last_band <= in_last;
      gsq       <= '0;
      ksq       <= '0;
      kc        <= '0;
    end
    if (cmd.mul_init) begin
      ua   <= a_abs[MAG_W-1:0];
      ub   <= b_abs;
      neg  <= opa[DW-1] ^ opb[DW-1] ^ cmd.mac.negate;
      prod <= '0;
    end
    if (cmd.mul_digit) begin
      prod <= (prod << DIGIT_W) + PROD_W'(digit_prod);
      ub   <= ub << DIGIT_W;
    end
    if (cmd.round) begin
      mag <= rnd_clip ? MAG_MAX : rnd_shift[MAG_W-1:0];
    end
    if (cmd.accum) begin
      case (cmd.mac.dst)
        ACC_GSQ:  gsq  <= acc_sat;
        ACC_KSQ:  ksq  <= acc_sat;
        ACC_IM:   im   <= acc_sat;
        ACC_KC:   kc   <= acc_sat;
        ACC_PSQ:  psq  <= acc_sat;
        ACC_QUAD: quad <= acc_sat;
        ACC_TERM: term <= acc_sat;
        default: begin
        end
      endcase
    end
  end

  // Running sum and clip flag for the current point.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      clip_seen   <= 1'b0;
    end else if (cmd.final_add) begin
      if (last_band) begin
        running_sum <= '0;
        clip_seen   <= 1'b0;
      end else begin
        running_sum <= fin_sat;
        clip_seen   <= clip_seen | fin_clip;
      end
    end else if (cmd.round) begin
      clip_seen <= clip_seen | rnd_clip;
    end else if (cmd.accum) begin
      clip_seen <= clip_seen | acc_clip;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  logic [SUM_WIDTH-1:0] out_sum;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sum <= fin_sat;
      out_sat <= clip_seen | fin_clip;
    end
  end

  assign out_data         = OUT_DATA_W'(out_sum);
  assign status.last_band = last_band;
  assign status.out_free  = !out_valid || out_ready;

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result written while the output register was still full");

  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && running_sum == '0 && !clip_seen))
    else $error("point did not close cleanly after its last band");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sum) && $stable(out_sat)))
    else $error("result changed while the receiver was stalling");

endmodule
`default_nettype wire
